@@ src/rvrt_pkg.sv @@
// rvrt_pkg: types, constants and arithmetic helpers for the rotation vector
// to rigid transform pipeline
// no dependencies
package rvrt_pkg;

  // Q2.30 constants
  localparam logic signed [34:0] ONE_Q30     = 35'sd1073741824;
  localparam logic signed [34:0] TWO_PI_Q30  = 35'sd6746518852;
  localparam logic signed [34:0] TWO_PI_X2   = 35'sd13493037704;
  localparam logic signed [34:0] PI_Q30      = 35'sd3373259426;
  localparam logic signed [34:0] HALF_PI_Q30 = 35'sd1686629713;
  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

  // payload carried from stage to stage
  typedef struct packed {
    logic signed [31:0] rx;
    logic signed [31:0] ry;
    logic signed [31:0] rz;
    logic signed [31:0] tx;
    logic signed [31:0] ty;
    logic signed [31:0] tz;
    logic [62:0]        sqx;
    logic [62:0]        sqy;
    logic [62:0]        sqz;
    logic [63:0]        sum;
    logic [35:0]        rem;
    logic [31:0]        root;
    logic               zero;
    logic [32:0]        drx;
    logic [32:0]        dry;
    logic [32:0]        drz;
    logic [30:0]        qx;
    logic [30:0]        qy;
    logic [30:0]        qz;
    logic signed [31:0] nx;
    logic signed [31:0] ny;
    logic signed [31:0] nz;
    logic signed [34:0] t;
    logic               flip;
    logic signed [33:0] cx;
    logic signed [33:0] cy;
    logic signed [33:0] cz;
    logic signed [31:0] c;
    logic signed [31:0] s;
    logic signed [32:0] omc;
    logic signed [31:0] pxx;
    logic signed [31:0] pxy;
    logic signed [31:0] pxz;
    logic signed [31:0] pyy;
    logic signed [31:0] pyz;
    logic signed [31:0] pzz;
    logic signed [31:0] psx;
    logic signed [31:0] psy;
    logic signed [31:0] psz;
    logic signed [32:0] axx;
    logic signed [32:0] axy;
    logic signed [32:0] axz;
    logic signed [32:0] ayy;
    logic signed [32:0] ayz;
    logic signed [32:0] azz;
  } pipe_t;

  // arctan(2^-i) in Q2.30, rounded to nearest
  function automatic logic signed [33:0] atan_q30(input int unsigned i);
    logic signed [33:0] v;
    case (i)
      0:  v = 34'sd843314857;
      1:  v = 34'sd497837829;
      2:  v = 34'sd263043837;
      3:  v = 34'sd133525159;
      4:  v = 34'sd67021687;
      5:  v = 34'sd33543516;
      6:  v = 34'sd16775851;
      7:  v = 34'sd8388437;
      8:  v = 34'sd4194283;
      9:  v = 34'sd2097149;
      10: v = 34'sd1048576;
      11: v = 34'sd524288;
      12: v = 34'sd262144;
      13: v = 34'sd131072;
      14: v = 34'sd65536;
      15: v = 34'sd32768;
      16: v = 34'sd16384;
      17: v = 34'sd8192;
      18: v = 34'sd4096;
      19: v = 34'sd2048;
      20: v = 34'sd1024;
      21: v = 34'sd512;
      22: v = 34'sd256;
      23: v = 34'sd128;
      24: v = 34'sd64;
      25: v = 34'sd32;
      26: v = 34'sd16;
      27: v = 34'sd8;
      28: v = 34'sd4;
      29: v = 34'sd2;
      30: v = 34'sd1;
      default: v = 34'sd0;
    endcase
    return v;
  endfunction

  // Q2.30 product, rounded half up
  function automatic logic signed [33:0] mulq(input logic signed [33:0] a,
                                              input logic signed [33:0] b);
    logic signed [67:0] p;
    p = a * b + 68'sd536870912;
    return p[63:30];
  endfunction

  // clamp to plus or minus one in Q2.30
  function automatic logic signed [31:0] clamp_one(input logic signed [34:0] v);
    logic signed [31:0] r;
    if (v > ONE_Q30) begin
      r = 32'sd1073741824;
    end else if (v < -ONE_Q30) begin
      r = -32'sd1073741824;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

@@ src/rotvec_to_rigid_transform_top.sv @@
// rotvec_to_rigid_transform_top: rotation vector plus translation to a rigid
// transform by the Rodrigues formula, fully pipelined
// depends on rvrt_pkg
//
// One request enters per cycle, and each request passes through the squared
// norm stages, the square root stages (one result bit per stage), the three
// parallel unit-axis divides (one quotient bit per stage), the angle reduction
// stages, TRIG_STEPS CORDIC stages, then one clamp stage and three multiply/sum
// stages. The whole pipe advances whenever the output register is empty or
// being taken, so a stall at the output holds every stage in place.
module rotvec_to_rigid_transform_top #(
  parameter int TRIG_STEPS = 24
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // rot_x, rot_y, rot_z, shift_x, shift_y, shift_z
  input  logic [191:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // r00, r01, r02, r10, r11, r12, r20, r21, r22,
  // out_shift_x, out_shift_y, out_shift_z
  output logic [383:0] m_tdata
);
  import rvrt_pkg::*;

  localparam int SQ0   = 2;
  localparam int DIV0  = SQ0 + 32;
  localparam int RED0  = DIV0 + 31;
  localparam int RED1  = RED0 + 1;
  localparam int COR0  = RED1 + 1;
  localparam int CLP   = COR0 + TRIG_STEPS;
  localparam int PM1   = CLP + 1;
  localparam int PM2   = PM1 + 1;
  localparam int NSTG  = PM2 + 2;

  pipe_t st [NSTG];
  pipe_t nxt [NSTG];
  logic [NSTG:0] vld;
  logic          adv;
  logic signed [31:0] r_out [9];

  // magnitude of a signed component
  function automatic logic [31:0] mag32(input logic signed [31:0] r);
    logic signed [31:0] n;
    n = -r;
    return r[31] ? n : r;
  endfunction

  // one restoring divide step: {quotient bit, new remainder}
  function automatic logic [33:0] div_step(input logic [32:0] rin,
                                           input logic [31:0] den);
    logic ge;
    logic [32:0] r;
    ge = rin >= {1'b0, den};
    r  = ge ? rin - {1'b0, den} : rin;
    return {ge, r};
  endfunction

  // signed unit component from quotient and sign
  function automatic logic signed [31:0] unit_comp(input logic [30:0] q,
                                                   input logic neg);
    logic [31:0] m;
    m = (q > 31'd1073741824) ? 32'd1073741824 : {1'b0, q};
    return neg ? -$signed(m) : $signed(m);
  endfunction

  // whole pipe moves when the output register is free
  assign adv      = !vld[NSTG] || m_tready;
  assign s_tready = adv;
  assign m_tvalid = vld[NSTG];
  assign vld[0]   = s_tvalid;

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vld[NSTG:1] <= '0;
    end else if (adv) begin
      vld[NSTG:1] <= vld[NSTG-1:0];
    end
  end

  for (genvar g = 0; g < NSTG - 1; g++) begin : g_stage
    if (g == 0) begin : g_sq
      // squares of the rotation vector
      always_comb begin
        logic signed [63:0] px, py, pz;
        nxt[g] = '0;
        nxt[g].rx = s_tdata[31:0];
        nxt[g].ry = s_tdata[63:32];
        nxt[g].rz = s_tdata[95:64];
        nxt[g].tx = s_tdata[127:96];
        nxt[g].ty = s_tdata[159:128];
        nxt[g].tz = s_tdata[191:160];
        px = nxt[g].rx * nxt[g].rx;
        py = nxt[g].ry * nxt[g].ry;
        pz = nxt[g].rz * nxt[g].rz;
        nxt[g].sqx = px[62:0];
        nxt[g].sqy = py[62:0];
        nxt[g].sqz = pz[62:0];
      end
    end else if (g == 1) begin : g_sum
      // squared norm
      always_comb begin
        nxt[g] = st[g-1];
        nxt[g].sum  = {1'b0, st[g-1].sqx} + {1'b0, st[g-1].sqy} + {1'b0, st[g-1].sqz};
        nxt[g].rem  = '0;
        nxt[g].root = '0;
      end
    end else if (g < DIV0) begin : g_sqrt
      // one root bit per stage, two radicand bits consumed
      localparam int K = 31 - (g - SQ0);
      always_comb begin
        logic [35:0] rsh, trial;
        nxt[g] = st[g-1];
        rsh   = {st[g-1].rem[33:0], st[g-1].sum[2*K+1 -: 2]};
        trial = {2'b00, st[g-1].root, 2'b01};
        if (rsh >= trial) begin
          nxt[g].rem  = rsh - trial;
          nxt[g].root = {st[g-1].root[30:0], 1'b1};
        end else begin
          nxt[g].rem  = rsh;
          nxt[g].root = {st[g-1].root[30:0], 1'b0};
        end
      end
    end else if (g < RED0) begin : g_div
      // one quotient bit per stage for each axis component
      localparam int B = 30 - (g - DIV0);
      always_comb begin
        logic [32:0] ix, iy, iz;
        logic [33:0] ox, oy, oz;
        nxt[g] = st[g-1];
        if (g == DIV0) begin
          ix = {1'b0, mag32(st[g-1].rx)};
          iy = {1'b0, mag32(st[g-1].ry)};
          iz = {1'b0, mag32(st[g-1].rz)};
          nxt[g].qx = '0;
          nxt[g].qy = '0;
          nxt[g].qz = '0;
          nxt[g].zero = (st[g-1].root == '0);
        end else begin
          ix = {st[g-1].drx[31:0], 1'b0};
          iy = {st[g-1].dry[31:0], 1'b0};
          iz = {st[g-1].drz[31:0], 1'b0};
        end
        ox = div_step(ix, st[g-1].root);
        oy = div_step(iy, st[g-1].root);
        oz = div_step(iz, st[g-1].root);
        nxt[g].drx = ox[32:0];
        nxt[g].dry = oy[32:0];
        nxt[g].drz = oz[32:0];
        nxt[g].qx[B] = ox[33];
        nxt[g].qy[B] = oy[33];
        nxt[g].qz[B] = oz[33];
      end
    end else if (g == RED0) begin : g_red0
      // angle to Q2.30 modulo two pi, signed unit axis
      always_comb begin
        logic signed [34:0] a4;
        nxt[g] = st[g-1];
        a4 = $signed({1'b0, st[g-1].root, 2'b00});
        if (a4 >= TWO_PI_X2) begin
          nxt[g].t = a4 - TWO_PI_X2;
        end else if (a4 >= TWO_PI_Q30) begin
          nxt[g].t = a4 - TWO_PI_Q30;
        end else begin
          nxt[g].t = a4;
        end
        nxt[g].nx = unit_comp(st[g-1].qx, st[g-1].rx[31]);
        nxt[g].ny = unit_comp(st[g-1].qy, st[g-1].ry[31]);
        nxt[g].nz = unit_comp(st[g-1].qz, st[g-1].rz[31]);
      end
    end else if (g == RED1) begin : g_red1
      // wrap into (-pi, pi], fold by pi into [-pi/2, pi/2]
      always_comb begin
        logic signed [34:0] t1, t2;
        nxt[g] = st[g-1];
        t1 = (st[g-1].t > PI_Q30) ? st[g-1].t - TWO_PI_Q30 : st[g-1].t;
        if (t1 > HALF_PI_Q30) begin
          t2 = t1 - PI_Q30;
          nxt[g].flip = 1'b1;
        end else if (t1 < -HALF_PI_Q30) begin
          t2 = t1 + PI_Q30;
          nxt[g].flip = 1'b1;
        end else begin
          t2 = t1;
          nxt[g].flip = 1'b0;
        end
        nxt[g].cx = CORDIC_GAIN;
        nxt[g].cy = '0;
        nxt[g].cz = t2[33:0];
      end
    end else if (g < CLP) begin : g_cordic
      // one CORDIC rotation per stage
      localparam int I = g - COR0;
      always_comb begin
        logic signed [33:0] dx, dy;
        nxt[g] = st[g-1];
        dx = st[g-1].cy >>> I;
        dy = st[g-1].cx >>> I;
        if (st[g-1].cz >= 0) begin
          nxt[g].cx = st[g-1].cx - dx;
          nxt[g].cy = st[g-1].cy + dy;
          nxt[g].cz = st[g-1].cz - atan_q30(I);
        end else begin
          nxt[g].cx = st[g-1].cx + dx;
          nxt[g].cy = st[g-1].cy - dy;
          nxt[g].cz = st[g-1].cz + atan_q30(I);
        end
      end
    end else if (g == CLP) begin : g_clamp
      // clamp and undo the fold
      always_comb begin
        logic signed [31:0] xc, yc;
        nxt[g] = st[g-1];
        xc = clamp_one(35'(st[g-1].cx));
        yc = clamp_one(35'(st[g-1].cy));
        nxt[g].c = st[g-1].flip ? -xc : xc;
        nxt[g].s = st[g-1].flip ? -yc : yc;
      end
    end else if (g == PM1) begin : g_mul1
      // axis outer products and axis times sine
      always_comb begin
        logic signed [33:0] x, y, z, sn, t;
        nxt[g] = st[g-1];
        x  = 34'(st[g-1].nx);
        y  = 34'(st[g-1].ny);
        z  = 34'(st[g-1].nz);
        sn = 34'(st[g-1].s);
        t  = mulq(x, x);  nxt[g].pxx = t[31:0];
        t  = mulq(x, y);  nxt[g].pxy = t[31:0];
        t  = mulq(x, z);  nxt[g].pxz = t[31:0];
        t  = mulq(y, y);  nxt[g].pyy = t[31:0];
        t  = mulq(y, z);  nxt[g].pyz = t[31:0];
        t  = mulq(z, z);  nxt[g].pzz = t[31:0];
        t  = mulq(x, sn); nxt[g].psx = t[31:0];
        t  = mulq(y, sn); nxt[g].psy = t[31:0];
        t  = mulq(z, sn); nxt[g].psz = t[31:0];
        nxt[g].omc = 33'sd1073741824 - 33'(st[g-1].c);
      end
    end else begin : g_mul2
      // outer products scaled by one minus cosine
      always_comb begin
        logic signed [33:0] om, t;
        nxt[g] = st[g-1];
        om = 34'(st[g-1].omc);
        t = mulq(34'(st[g-1].pxx), om); nxt[g].axx = t[32:0];
        t = mulq(34'(st[g-1].pxy), om); nxt[g].axy = t[32:0];
        t = mulq(34'(st[g-1].pxz), om); nxt[g].axz = t[32:0];
        t = mulq(34'(st[g-1].pyy), om); nxt[g].ayy = t[32:0];
        t = mulq(34'(st[g-1].pyz), om); nxt[g].ayz = t[32:0];
        t = mulq(34'(st[g-1].pzz), om); nxt[g].azz = t[32:0];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        st[g] <= nxt[g];
      end
    end
  end

  // final sums, clamp, identity for a zero angle
  always_comb begin
    pipe_t p;
    logic signed [34:0] c, sx, sy, sz;
    p  = st[NSTG-2];
    c  = 35'(p.c);
    sx = 35'(p.psx);
    sy = 35'(p.psy);
    sz = 35'(p.psz);
    nxt[NSTG-1] = p;
    if (p.zero) begin
      for (int k = 0; k < 9; k++) begin
        r_out[k] = (k % 4 == 0) ? 32'sd1073741824 : 32'sd0;
      end
    end else begin
      r_out[0] = clamp_one(c + 35'(p.axx));
      r_out[1] = clamp_one(35'(p.axy) - sz);
      r_out[2] = clamp_one(35'(p.axz) + sy);
      r_out[3] = clamp_one(35'(p.axy) + sz);
      r_out[4] = clamp_one(c + 35'(p.ayy));
      r_out[5] = clamp_one(35'(p.ayz) - sx);
      r_out[6] = clamp_one(35'(p.axz) - sy);
      r_out[7] = clamp_one(35'(p.ayz) + sx);
      r_out[8] = clamp_one(c + 35'(p.azz));
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (adv) begin
      st[NSTG-1] <= nxt[NSTG-1];
      for (int k = 0; k < 9; k++) begin
        m_tdata[32*k +: 32] <= r_out[k];
      end
      m_tdata[319:288] <= nxt[NSTG-1].tx;
      m_tdata[351:320] <= nxt[NSTG-1].ty;
      m_tdata[383:352] <= nxt[NSTG-1].tz;
    end
  end

  // first stage valid follows the accepted request
  a_first_vld : assert property (@(posedge clk) disable iff (rst)
    adv |=> vld[1] == $past(s_tvalid))
    else $error("first stage valid does not match accepted request");

  // a held result keeps its payload
  a_hold : assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("stalled result changed");

  // the diagonal entries r00 and r11 stay within plus or minus one
  a_range : assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ($signed(m_tdata[31:0]) <= 32'sd1073741824 &&
                  $signed(m_tdata[31:0]) >= -32'sd1073741824 &&
                  $signed(m_tdata[159:128]) <= 32'sd1073741824 &&
                  $signed(m_tdata[159:128]) >= -32'sd1073741824))
    else $error("matrix entry out of range");

endmodule

@@ sim/tb_rotvec_to_rigid_transform_top.sv @@
// tb_rotvec_to_rigid_transform_top: self-checking bench for the rotation vector
// to rigid transform pipeline, with its own fixed-point rotation predictor
// depends on rvrt_pkg and rotvec_to_rigid_transform_top
module tb_rotvec_to_rigid_transform_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STEPS = 24;
  localparam int PIPE_LAT = 71 + STEPS;
  localparam int IDLE_LIMIT = 20000;
  localparam longint Q_ONE = 64'sd1073741824;
  localparam longint Q_TWO_PI = 64'sd6746518852;
  localparam longint Q_PI = 64'sd3373259426;
  localparam longint Q_HALF_PI = 64'sd1686629713;
  localparam longint Q_GAIN = 64'sd652032874;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [191:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [383:0] m_tdata;

  logic [383:0] pending_transforms[$];
  int mismatches = 0;
  int requests_sent = 0;
  int transforms_seen = 0;
  int idle_cycles = 0;
  bit stall_free = 0;
  int hold_off = 0;
  event hold_start;

  rotvec_to_rigid_transform_top #(.TRIG_STEPS(STEPS)) dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // arctan(2^-i) in Q2.30
  function automatic longint atan_step(int i);
    longint tab[32] = '{843314857, 497837829, 263043837, 133525159, 67021687,
      33543516, 16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144,
      131072, 65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64,
      32, 16, 8, 4, 2, 1, 0};
    return tab[i];
  endfunction

  function automatic longint sat_one(longint v);
    if (v > Q_ONE) return Q_ONE;
    if (v < -Q_ONE) return -Q_ONE;
    return v;
  endfunction

  // Q2.30 product, round half up
  function automatic longint qmul(longint a, longint b);
    return (a * b + 64'sd536870912) >>> 30;
  endfunction

  function automatic longint int_sqrt(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return longint'(res);
  endfunction

  function automatic longint axis_comp(longint r, longint angle);
    longint unsigned mag, q;
    mag = (r < 0) ? -r : r;
    q = (mag << 30) / longint'(angle);
    if (q > Q_ONE) q = Q_ONE;
    return (r < 0) ? -longint'(q) : longint'(q);
  endfunction

  // full transform for one request
  function automatic logic [383:0] rigid_transform(logic [191:0] req);
    longint rx, ry, rz, angle, nx, ny, nz, c, s, omc, t, x, y, z, dx, dy;
    longint m[9];
    longint unsigned sum;
    bit flip;
    logic [383:0] res;
    rx = longint'($signed(req[31:0]));
    ry = longint'($signed(req[63:32]));
    rz = longint'($signed(req[95:64]));
    sum = longint'(rx * rx) + longint'(ry * ry) + longint'(rz * rz);
    angle = int_sqrt(sum);
    if (angle == 0) begin
      foreach (m[k]) m[k] = (k % 4 == 0) ? Q_ONE : 0;
    end else begin
      nx = axis_comp(rx, angle);
      ny = axis_comp(ry, angle);
      nz = axis_comp(rz, angle);
      // range reduction into [-pi/2, pi/2] with sign fold
      t = (angle <<< 2) % Q_TWO_PI;
      flip = 0;
      if (t > Q_PI) t -= Q_TWO_PI;
      if (t > Q_HALF_PI) begin
        t -= Q_PI;
        flip = 1;
      end else if (t < -Q_HALF_PI) begin
        t += Q_PI;
        flip = 1;
      end
      x = Q_GAIN;
      y = 0;
      z = t;
      for (int i = 0; i < STEPS && i < 32; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (z >= 0) begin
          x -= dx; y += dy; z -= atan_step(i);
        end else begin
          x += dx; y -= dy; z += atan_step(i);
        end
      end
      c = sat_one(x);
      s = sat_one(y);
      if (flip) begin
        c = -c; s = -s;
      end
      omc = Q_ONE - c;
      m[0] = c + qmul(qmul(nx, nx), omc);
      m[1] = qmul(qmul(nx, ny), omc) - qmul(nz, s);
      m[2] = qmul(qmul(nx, nz), omc) + qmul(ny, s);
      m[3] = qmul(qmul(ny, nx), omc) + qmul(nz, s);
      m[4] = c + qmul(qmul(ny, ny), omc);
      m[5] = qmul(qmul(ny, nz), omc) - qmul(nx, s);
      m[6] = qmul(qmul(nz, nx), omc) - qmul(ny, s);
      m[7] = qmul(qmul(nz, ny), omc) + qmul(nx, s);
      m[8] = c + qmul(qmul(nz, nz), omc);
    end
    for (int k = 0; k < 9; k++) res[32*k +: 32] = 32'(sat_one(m[k]));
    res[383:288] = req[191:96];
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, $signed(got),
             $signed(want), $realtime);
    mismatches++;
  endtask

  // send one request, honoring random idling
  task automatic send_request(logic [31:0] rx, ry, rz, tx, ty, tz);
    while (!stall_free && $urandom_range(99) < 7) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {tz, ty, tx, rz, ry, rx};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pending_transforms.push_back(rigid_transform({tz, ty, tx, rz, ry, rx}));
    requests_sent++;
  endtask

  function automatic logic [31:0] rand_rot();
    case ($urandom_range(3))
      0: return $urandom;
      1: return 32'($signed($urandom_range(2000)) - 1000);
      2: return 32'($signed($urandom_range(1 << 29)) - (1 << 28));
      default: return ($urandom_range(1)) ? 32'h7fffffff : 32'h80000000;
    endcase
  endfunction

  // long receiver hold-off, counted in cycles
  always begin
    @(hold_start);
    hold_off <= 400;
    @(posedge clk);
    while (hold_off > 0) begin
      hold_off <= hold_off - 1;
      @(posedge clk);
    end
  end

  // receiver: ready randomization, long hold-off, result check
  always @(posedge clk) begin
    logic [383:0] want;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        transforms_seen++;
        if (pending_transforms.size() == 0) begin
          report_mismatch("unexpected transform", m_tdata[31:0], 32'd0);
        end else begin
          want = pending_transforms.pop_front();
          for (int k = 0; k < 12; k++)
            if (m_tdata[32*k +: 32] !== want[32*k +: 32])
              report_mismatch($sformatf("field %0d", k), m_tdata[32*k +: 32],
                              want[32*k +: 32]);
        end
      end
      if (hold_off > 0) begin
        m_tready <= 1'b0;
      end else begin
        m_tready <= stall_free || ($urandom_range(99) >= 7);
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IDLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic test_directed();
    logic [31:0] ext[6] = '{32'h0, 32'h7fffffff, 32'h80000000, 32'h1, 32'hffffffff,
                            32'h10000000};
    send_request(0, 0, 0, 32'h12345678, 32'h80000000, 32'h7fffffff);
    send_request(0, 0, 0, 32'hffffffff, 0, 32'h1);
    for (int i = 1; i < 6; i++) send_request(ext[i], 0, 0, ext[i], ext[6 - i], 0);
    for (int i = 1; i < 6; i++) send_request(0, ext[i], 0, 0, 0, ext[i]);
    for (int i = 1; i < 6; i++) send_request(0, 0, ext[i], ext[i], 0, 0);
    send_request(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 0, 0, 0);
    send_request(32'h80000000, 32'h80000000, 32'h80000000, 0, 0, 0);
    // angles near pi and pi/2 (Q4.28)
    send_request(32'd843314857, 0, 0, 0, 0, 0);
    send_request(0, 32'd421657428, 0, 0, 0, 0);
    send_request(32'd300000000, 32'hEE6B2800, 32'd123456789, 0, 0, 0);
  endtask

  task automatic test_random(int count);
    for (int i = 0; i < count; i++)
      send_request(rand_rot(), rand_rot(), rand_rot(), $urandom, $urandom, $urandom);
  endtask

  task automatic test_backpressure();
    -> hold_start;
    test_random(200);
  endtask

  task automatic test_streaming();
    stall_free = 1;
    test_random(150);
    stall_free = 0;
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(300);
    test_backpressure();
    test_streaming();
    test_random(230);
    s_tvalid <= 1'b0;
    while (pending_transforms.size() != 0) @(posedge clk);
    repeat (PIPE_LAT + 10) @(posedge clk);
    $display("covered %0d poses incl. zero, extreme and near-pi vectors;", requests_sent);
    $display("%0d transforms checked under random stalls and a long output hold",
             transforms_seen);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
